[sv/icgs_pkg.sv]
// ---------------------------------------------------------------------------
// icgs_pkg
// shared widths, codes and transfer types of the gaussian cluster score unit
// ---------------------------------------------------------------------------
package icgs_pkg;

  localparam int DimMax   = 16;
  localparam int PosW     = 4;
  localparam int DimW     = 5;
  localparam int FracBits = 16;
  localparam int ValW     = 32;
  localparam int SumW     = 48;
  localparam int CntW     = 16;
  localparam int AccW     = 64;
  localparam int LlW      = 40;
  localparam int ScaleW   = 32;
  localparam int CfgIdxW  = 3;
  localparam int CfgW     = 40;
  localparam int DivCntW  = 6;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] REG_DIMENSIONS   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_INV_SCALE_C  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LOG_NORM_C   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INV_SCALE_A  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LOG_NORM_A   = 3'd4;

  typedef enum logic [1:0] {
    OP_ADD        = 2'd0,
    OP_REMOVE     = 2'd1,
    OP_SCORE_COMP = 2'd2,
    OP_SCORE_NEW  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]             operation;
    logic signed [ValW-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [LlW-1:0] log_likelihood;
    logic [CntW-1:0]       point_count;
    logic                  empty_error;
    logic                  count_saturated;
  } out_item_t;

endpackage

[sv/isotropic_gaussian_cluster_score_unit.sv]
// ---------------------------------------------------------------------------
// isotropic_gaussian_cluster_score_unit
// one mixture component: sum vector, point count and gaussian log-likelihood
// ---------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------
//  in       | input     | in_valid_i / in_stall_o   | in_data_i  (in_item_t)
//  out      | output    | out_valid_o / out_stall_i | out_data_o (out_item_t)
//  cfg      | input     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
//  add or remove element, or score against an empty component: S_EXEC, S_POST
//  new-cluster score element: S_EXEC, S_SQ, S_ACC, S_POST
//  component score element: S_EXEC, S_DIV, S_SQ, S_ACC, S_POST; S_DIV waits
//  for the bit-serial divider (48 steps) that forms sum / count; the last
//  element of a score adds S_MLO, S_MHI and S_FIN for the split 64x32 final
//  product, and every last element ends with S_OUT for the output load
//  reset clears the sums, count and position at once; no clearing pass
//  one element in flight; a stalled output holds only the final load
// ---------------------------------------------------------------------------
module isotropic_gaussian_cluster_score_unit import icgs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_DIV, S_SQ, S_ACC, S_POST, S_MLO, S_MHI, S_FIN, S_OUT
  } state_e;

  localparam int Sh = FracBits + 1;

  // configuration registers
  logic [DimW-1:0]          dim_q;
  logic [ScaleW-1:0]        inv_comp_q;
  logic signed [LlW-1:0]    ln_comp_q;
  logic [ScaleW-1:0]        inv_all_q;
  logic signed [LlW-1:0]    ln_all_q;

  // component state
  logic signed [SumW-1:0]   sum_q [DimMax];
  logic [CntW-1:0]          cnt_q;
  logic [PosW-1:0]          pos_q;
  logic [AccW-1:0]          acc_q;
  op_e                      pend_q;

  // sequencer and datapath registers
  state_e                   state_q;
  logic signed [ValW-1:0]   x_q;
  logic                     last_q;
  logic                     neg_q;
  logic signed [SumW:0]     diff_q;
  logic [AccW-1:0]          prod_q;
  logic [AccW-1:0]          plo_q;
  logic signed [LlW-1:0]    res_ll_q;
  logic                     res_empty_q;
  logic                     res_sat_q;
  logic                     out_valid_q;
  out_item_t                out_q;

  logic [DimW-1:0]          dim_eff;
  logic                     in_xfer;
  logic signed [SumW-1:0]   sum_sel;
  logic signed [SumW:0]     sum_ext;
  logic signed [SumW:0]     x_ext;
  logic signed [SumW:0]     upd;
  logic signed [SumW-1:0]   upd_sat;
  logic [SumW-1:0]          sum_mag;
  logic                     div_start;
  logic                     div_done;
  logic [SumW-1:0]          quo;
  logic signed [SumW:0]     q_ext;
  logic [SumW:0]            dmag;
  logic [ValW-1:0]          dclamp;
  logic [ValW-1:0]          mul_a;
  logic [ScaleW-1:0]        mul_b;
  logic [AccW-1:0]          mul_p;
  logic [AccW-FracBits-1:0] sq;
  logic [AccW:0]            acc_sum;
  logic [ScaleW-1:0]        inv_sel;
  logic signed [LlW-1:0]    ln_sel;
  logic [SumW-1:0]          half;
  logic signed [LlW+3:0]    ll_wide;
  logic signed [LlW-1:0]    ll_sat;

  // 0 behaves as 1, anything above the sum vector depth as the full depth
  always_comb begin
    if (dim_q == '0) begin
      dim_eff = DimW'(1);
    end else if (dim_q > DimW'(DimMax)) begin
      dim_eff = DimW'(DimMax);
    end else begin
      dim_eff = dim_q;
    end
  end

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // element update with saturation to the 48-bit sum range
  assign sum_sel = sum_q[pos_q];
  assign sum_ext = (SumW+1)'(sum_sel);
  assign x_ext   = (SumW+1)'(x_q);
  assign upd     = (pend_q == OP_ADD) ? sum_ext + x_ext : sum_ext - x_ext;

  always_comb begin
    if (upd[SumW] != upd[SumW-1]) begin
      upd_sat = upd[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      upd_sat = upd[SumW-1:0];
    end
  end

  // mean = sum / count, truncated toward zero through magnitudes
  assign sum_mag   = sum_sel[SumW-1] ? SumW'(-sum_ext) : sum_sel;
  assign div_start = (state_q == S_EXEC) && (pend_q == OP_SCORE_COMP) && (cnt_q != '0);

  icgs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_mag),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign q_ext = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  // centred magnitude, clamped to 31 bits
  assign dmag   = diff_q[SumW] ? (SumW+1)'(-diff_q) : diff_q;
  assign dclamp = (dmag > (SumW+1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : dmag[ValW-1:0];

  assign inv_sel = (pend_q == OP_SCORE_COMP) ? inv_comp_q : inv_all_q;
  assign ln_sel  = (pend_q == OP_SCORE_COMP) ? ln_comp_q : ln_all_q;

  // the one shared 32x32 multiplier: square, then low and high final products
  always_comb begin
    case (state_q)
      S_SQ: begin
        mul_a = dclamp;
        mul_b = dclamp;
      end
      S_MLO: begin
        mul_a = acc_q[ValW-1:0];
        mul_b = inv_sel;
      end
      default: begin
        mul_a = acc_q[AccW-1:ValW];
        mul_b = inv_sel;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign sq      = prod_q[AccW-1:FracBits];
  assign acc_sum = {1'b0, acc_q} + (AccW+1)'(sq);

  // half term: prod_q holds the high product, plo_q the low one
  always_comb begin
    if (prod_q >= (AccW'(1) << (Sh + 10))) begin
      half = SumW'(1) << 42;
    end else begin
      half = SumW'(prod_q << (ValW - Sh)) + SumW'(plo_q >> Sh);
      if (half > (SumW'(1) << 42)) begin
        half = SumW'(1) << 42;
      end
    end
  end

  assign ll_wide = (LlW+4)'(ln_sel) - $signed({1'b0, half[LlW+2:0]});

  always_comb begin
    if (ll_wide < -(LlW+4)'(64'sd549755813888)) begin
      ll_sat = {1'b1, {(LlW-1){1'b0}}};
    end else if (ll_wide > (LlW+4)'(64'sd549755813887)) begin
      ll_sat = {1'b0, {(LlW-1){1'b1}}};
    end else begin
      ll_sat = ll_wide[LlW-1:0];
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q      <= DimW'(1);
      inv_comp_q <= ScaleW'(65536);
      ln_comp_q  <= '0;
      inv_all_q  <= ScaleW'(65536);
      ln_all_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DIMENSIONS:  dim_q      <= cfg_data_i[DimW-1:0];
        REG_INV_SCALE_C: inv_comp_q <= cfg_data_i[ScaleW-1:0];
        REG_LOG_NORM_C:  ln_comp_q  <= cfg_data_i;
        REG_INV_SCALE_A: inv_all_q  <= cfg_data_i[ScaleW-1:0];
        REG_LOG_NORM_A:  ln_all_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer, component state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int i = 0; i < DimMax; i++) begin
        sum_q[i] <= '0;
      end
      cnt_q       <= '0;
      pos_q       <= '0;
      acc_q       <= '0;
      pend_q      <= OP_ADD;
      out_valid_q <= 1'b0;
      x_q         <= '0;
      last_q      <= 1'b0;
      neg_q       <= 1'b0;
      diff_q      <= '0;
      prod_q      <= '0;
      plo_q       <= '0;
      res_ll_q    <= '0;
      res_empty_q <= 1'b0;
      res_sat_q   <= 1'b0;
      out_q       <= '0;
    end else begin
      // the output load below takes over the valid bit while in S_OUT
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            x_q    <= in_data_i.element_value;
            last_q <= ((DimW'(pos_q) + DimW'(1)) >= dim_eff);
            // first element of a point picks the operation
            if (pos_q == '0) begin
              pend_q <= op_e'(in_data_i.operation);
              acc_q  <= '0;
            end
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (pend_q)
            OP_ADD: begin
              if (cnt_q != '1) begin
                sum_q[pos_q] <= upd_sat;
              end
              state_q <= S_POST;
            end
            OP_REMOVE: begin
              if (cnt_q != '0) begin
                sum_q[pos_q] <= upd_sat;
              end
              state_q <= S_POST;
            end
            OP_SCORE_COMP: begin
              neg_q   <= sum_sel[SumW-1];
              state_q <= (cnt_q != '0) ? S_DIV : S_POST;
            end
            default: begin
              diff_q  <= x_ext;
              state_q <= S_SQ;
            end
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            diff_q  <= x_ext - q_ext;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          prod_q  <= mul_p;
          state_q <= S_ACC;
        end
        S_ACC: begin
          acc_q   <= acc_sum[AccW] ? '1 : acc_sum[AccW-1:0];
          state_q <= S_POST;
        end
        S_POST: begin
          if (!last_q) begin
            pos_q   <= pos_q + 1'b1;
            state_q <= S_IDLE;
          end else begin
            pos_q       <= '0;
            res_ll_q    <= '0;
            res_empty_q <= 1'b0;
            res_sat_q   <= 1'b0;
            state_q     <= S_OUT;
            case (pend_q)
              OP_ADD: begin
                if (cnt_q != '1) begin
                  cnt_q <= cnt_q + 1'b1;
                end else begin
                  res_sat_q <= 1'b1;
                end
              end
              OP_REMOVE: begin
                if (cnt_q != '0) begin
                  cnt_q <= cnt_q - 1'b1;
                end else begin
                  res_sat_q <= 1'b1;
                end
              end
              OP_SCORE_COMP: begin
                if (cnt_q == '0) begin
                  res_empty_q <= 1'b1;
                end else begin
                  state_q <= S_MLO;
                end
              end
              default: state_q <= S_MLO;
            endcase
          end
        end
        S_MLO: begin
          prod_q  <= mul_p;
          state_q <= S_MHI;
        end
        S_MHI: begin
          plo_q   <= prod_q;
          prod_q  <= mul_p;
          state_q <= S_FIN;
        end
        S_FIN: begin
          res_ll_q <= ll_sat;
          state_q  <= S_OUT;
        end
        S_OUT: begin
          // load the result once the output register is free
          if (!out_valid_q || !out_stall_i) begin
            out_q.log_likelihood  <= res_ll_q;
            out_q.point_count     <= cnt_q;
            out_q.empty_error     <= res_empty_q;
            out_q.count_saturated <= res_sat_q;
            out_valid_q           <= 1'b1;
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a result never carries both flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.empty_error && out_q.count_saturated))
    else $error("both result flags set");

  // an empty component score reports no likelihood
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.empty_error) |-> (out_q.log_likelihood == '0))
    else $error("empty score with nonzero likelihood");

  // the divider only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside its wait state");

  // a divide, only started for a nonempty component, moves the sequencer into its wait state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == S_DIV))
    else $error("divide started without entering its wait state");

endmodule

[sv/icgs_div.sv]
// ---------------------------------------------------------------------------
// icgs_div
// restoring divider, one quotient bit per cycle, unsigned magnitudes
// ---------------------------------------------------------------------------
module icgs_div import icgs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SumW-1:0] dividend_i,
  input  logic [CntW-1:0] divisor_i,
  output logic            done_o,
  output logic [SumW-1:0] quotient_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] step_q;
  logic [CntW-1:0]    rem_q;
  logic [SumW-1:0]    quo_q;
  logic [CntW-1:0]    div_q;
  logic [CntW:0]      trial;
  logic               fits;

  assign trial = {rem_q, quo_q[SumW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == DivCntW'(SumW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == DivCntW'(SumW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? CntW'(trial - {1'b0, div_q}) : trial[CntW-1:0];
      quo_q <= {quo_q[SumW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
